/* rtl/core/capture_period_duty_meter_core_assert.svh */
// Assertion macros used by the meter core module
`ifndef CAPTURE_PERIOD_DUTY_METER_CORE_ASSERT_SVH
`define CAPTURE_PERIOD_DUTY_METER_CORE_ASSERT_SVH
// Check an implication on every clock edge out of reset
`define CPDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define CPDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/cpdm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the capture period and duty meter
package cpdm_pkg;
  localparam int RingDepth = 32;
  localparam int SlotW = $clog2(RingDepth);

  localparam logic [2:0] OP_CAPTURE = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_PERIOD  = 3'd2;
  localparam logic [2:0] OP_DUTY    = 3'd3;
  localparam logic [2:0] OP_COUNT   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FEW      = 3'd1;
  localparam logic [2:0] ST_OVERWR   = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [15:0] TolReset = 16'd20;
  localparam logic [11:0] RatioMax = 12'd4095;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] capture_time;
    logic        query_edge;
    logic        pin_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  status;
  } out_item_t;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [15:0] high;
    logic [15:0] per;
  } div_req_t;
endpackage

/* rtl/core/capture_period_duty_meter_core.sv */
`timescale 1ns / 1ps
// Top level of the capture period and duty meter
// Capture, tick and unused ops are taken in the idle state; a count read goes to the output state.
// Period query: five reads of the timestamp RAM, evaluate, output.
// Duty query: two 28-step serial divisions after the reads; plus any output wait.
// One transaction in work at a time; the output register frees the input side.
// Reset (synchronous, rst_n low) clears control state; per-slot valid bits zero unwritten slots.
module capture_period_duty_meter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cpdm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpdm_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import cpdm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_DIV2 = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;

  logic [3:0]  st_r, st_nxt;
  in_item_t    item_r, item_nxt;
  logic [15:0] tol_r;
  logic [SlotW-1:0] wslot_r, wslot_nxt, gslot_r, gslot_nxt, base_r, base_nxt;
  logic        armed_r, armed_nxt, ow_r, ow_nxt, owq_r, owq_nxt;
  logic [7:0]  ethis_r, ethis_nxt, elast_r, elast_nxt;
  logic [15:0] pulse_r, pulse_nxt;
  logic [15:0] ram [RingDepth];
  logic [RingDepth-1:0] vld_r, vld_nxt;
  logic [15:0] rdata_r;
  logic        rvld_r;
  logic [SlotW-1:0] raddr;
  logic [2:0]  rcnt_r, rcnt_nxt;
  logic [15:0] t_r [4];
  logic [15:0] t4;
  logic [15:0] r1_r, r1_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   out_r, out_nxt;
  out_item_t   res_r, res_nxt;
  logic        we;
  logic [SlotW-1:0] nslot;
  logic [8:0]  total;
  logic [15:0] p1, p2, h1, h2, d16;
  logic [16:0] sum;
  div_req_t    dreq;
  logic        ddone;
  logic [11:0] dratio;
  logic [2:0]  rcnt_d_r;

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, tol_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TolReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      tol_r <= cfg_pwdata[15:0];
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = out_r;
  assign total = {1'b0, ethis_r} + {1'b0, elast_r};
  assign nslot = wslot_r + SlotW'(1);
  assign we = (st_r == S_IDLE) && in_valid && in_data.op == OP_CAPTURE;
  // Read order: base, base-1, base-2, base-3, base-4
  always_comb begin
    case (rcnt_r)
      3'd0: raddr = base_r;
      3'd1: raddr = base_r - SlotW'(1);
      3'd2: raddr = base_r - SlotW'(2);
      3'd3: raddr = base_r - SlotW'(3);
      default: raddr = base_r - SlotW'(4);
    endcase
  end

  // Timestamp RAM, one write port and one read port
  always_ff @(posedge clk) begin
    if (we) ram[nslot] <= in_data.capture_time;
    rdata_r <= ram[raddr];
  end

  // Latch the first four read words; the fifth stays on the read port
  always_ff @(posedge clk) begin
    if (!rst_n) rvld_r <= 1'b0;
    else rvld_r <= vld_r[raddr];
    rcnt_d_r <= rcnt_r;
    if (st_r == S_RD && rcnt_d_r != rcnt_r && rcnt_d_r < 3'd4)
      t_r[rcnt_d_r[1:0]] <= rvld_r ? rdata_r : 16'd0;
  end

  // Spans: t0=a,t1=a-1,t2=a-2,t3=a-3,a-4 arrives last
  assign t4 = rvld_r ? rdata_r : 16'd0;
  assign p1 = t_r[0] - t_r[2];
  assign p2 = t_r[2] - t4;
  assign h1 = t_r[0] - t_r[1];
  assign h2 = t_r[2] - t_r[3];

  cpdm_ratio_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .ratio(dratio));

  always_comb begin
    st_nxt = st_r; item_nxt = item_r; wslot_nxt = wslot_r; gslot_nxt = gslot_r;
    base_nxt = base_r; armed_nxt = armed_r; ow_nxt = ow_r; owq_nxt = owq_r;
    ethis_nxt = ethis_r; elast_nxt = elast_r; pulse_nxt = pulse_r;
    vld_nxt = vld_r; rcnt_nxt = rcnt_r; r1_nxt = r1_r; ov_nxt = ov_r; out_nxt = out_r;
    res_nxt = res_r;
    dreq = '0; d16 = '0; sum = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt = '0;
          case (in_data.op)
            OP_CAPTURE: begin
              wslot_nxt = nslot;
              vld_nxt[nslot] = 1'b1;
              if (armed_r && gslot_r == nslot) ow_nxt = 1'b1;
              if (nslot[0] && pulse_r != 16'hFFFF) pulse_nxt = pulse_r + 16'd1;
              if (ethis_r != 8'hFF) ethis_nxt = ethis_r + 8'd1;
            end
            OP_TICK: begin
              elast_nxt = ethis_r;
              ethis_nxt = '0;
            end
            OP_PERIOD, OP_DUTY: begin
              if (total > 9'd4) begin
                owq_nxt = ow_r;
                gslot_nxt = wslot_r - SlotW'(5);
                armed_nxt = 1'b1;
                ow_nxt = 1'b0;
                if ((in_data.op == OP_PERIOD) ?
                    (in_data.query_edge ^ wslot_r[0]) :
                    (!in_data.query_edge ^ wslot_r[0]))
                  base_nxt = wslot_r - SlotW'(1);
                else base_nxt = wslot_r;
                rcnt_nxt = '0;
                st_nxt = S_RD;
              end else begin
                if (in_data.op == OP_DUTY && total == 9'd0) begin
                  res_nxt.value = (!in_data.query_edge ^ in_data.pin_level) ?
                                  16'd4095 : 16'd0;
                end else res_nxt.status = ST_FEW;
                st_nxt = S_OUT;
              end
            end
            OP_COUNT: begin
              res_nxt.value = pulse_r;
              pulse_nxt = '0;
              st_nxt = S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (rcnt_r != 3'd5) rcnt_nxt = rcnt_r + 3'd1;
        if (rcnt_r == 3'd5) st_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (owq_r) begin
          res_nxt.status = ST_OVERWR; st_nxt = S_OUT;
        end else if (item_r.op == OP_PERIOD) begin
          d16 = (p1 > p2) ? p1 - p2 : p2 - p1;
          sum = {1'b0, p1} + {1'b0, p2};
          if (d16 < tol_r) res_nxt.value = sum[16:1];
          else res_nxt.status = ST_MISMATCH;
          st_nxt = S_OUT;
        end else if (p1 == 16'd0 || p2 == 16'd0) begin
          res_nxt.status = ST_ZERO; st_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1; dreq.high = h1; dreq.per = p1;
          // Hold the second period p2 for the second ratio
          r1_nxt = p2;
          st_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (ddone) begin
          res_nxt.value = {4'd0, dratio};
          dreq.start = 1'b1; dreq.high = h2; dreq.per = r1_r;
          st_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (ddone) begin
          d16 = (res_r.value > {4'd0, dratio}) ? res_r.value - {4'd0, dratio} :
                {4'd0, dratio} - res_r.value;
          sum = {1'b0, res_r.value} + {5'd0, dratio};
          if (d16 < tol_r) res_nxt.value = sum[16:1];
          else begin
            res_nxt.value = '0; res_nxt.status = ST_MISMATCH;
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output register once it is free
        if (!ov_r || !out_stall) begin
          out_nxt = res_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Keep the RAM read port on slot a-4 while evaluating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wslot_r <= '1; gslot_r <= '0; armed_r <= 1'b0; ow_r <= 1'b0;
      owq_r <= 1'b0; ethis_r <= '0; elast_r <= '0; pulse_r <= '0; vld_r <= '0;
      rcnt_r <= '0; ov_r <= 1'b0; base_r <= '0;
    end else begin
      st_r <= st_nxt; wslot_r <= wslot_nxt; gslot_r <= gslot_nxt; armed_r <= armed_nxt;
      ow_r <= ow_nxt; owq_r <= owq_nxt; ethis_r <= ethis_nxt; elast_r <= elast_nxt;
      pulse_r <= pulse_nxt; vld_r <= vld_nxt; rcnt_r <= rcnt_nxt; ov_r <= ov_nxt;
      base_r <= base_nxt;
    end
    item_r <= item_nxt; r1_r <= r1_nxt; out_r <= out_nxt; res_r <= res_nxt;
  end

  `include "capture_period_duty_meter_core_assert.svh"
  `CPDM_ASSERT_IMP(a_err_zero, out_valid && out_data.status != ST_OK, out_data.value == 16'd0)
  `CPDM_ASSERT_IMP(a_busy_stall, st_r != S_IDLE, in_stall)
  `CPDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

/* rtl/core/cpdm_ratio_div.sv */
`timescale 1ns / 1ps
// Restoring divider giving a saturated 12-bit high/period ratio
module cpdm_ratio_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cpdm_pkg::div_req_t req,
  output logic              done,
  output logic [11:0]       ratio
);
  import cpdm_pkg::*;

  logic [27:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] per_r, per_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;
  logic [27:0] quo_last;

  assign trial = {rem_r[15:0], quo_r[27]};

  // One quotient bit per cycle over 28 dividend bits
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    per_nxt = per_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      quo_nxt = {req.high, 12'd0};
      rem_nxt = '0;
      per_nxt = req.per;
      cnt_nxt = 5'd27;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, per_r}) begin
        rem_nxt = trial - {1'b0, per_r};
        quo_nxt = {quo_r[26:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[26:0], 1'b0};
      end
      if (cnt_r == 5'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    per_r <= per_nxt;
  end

  assign done = busy_r && (cnt_r == 5'd0);
  // Saturate the quotient that the last step produces, independent of a new start
  assign quo_last = {quo_r[26:0], (trial >= {1'b0, per_r})};
  assign ratio = (quo_last[27:12] != 16'd0) ? RatioMax : quo_last[11:0];
endmodule

/* sim/cpdm_checker.sv */
`timescale 1ns / 1ps
// Checker for the meter core: mirrors its state, predicts results and compares them
module cpdm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cpdm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cpdm_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_tol,
  output int                  fail_count,
  output int                  pending
);
  import cpdm_pkg::*;

  localparam int Depth = RingDepth;

  logic [15:0]      tol;
  logic [SlotW-1:0] wr_slot;
  logic [15:0]      stamps [Depth];
  logic [SlotW-1:0] guard_slot;
  logic             guard_on;
  logic             overwritten;
  logic [7:0]       edges_now;
  logic [7:0]       edges_prev;
  logic [15:0]      pulses;
  out_item_t        expected_results [$];

  function automatic logic [SlotW-1:0] slot_back(logic [SlotW-1:0] s, int k);
    return SlotW'((int'(s) + Depth - k) % Depth);
  endfunction

  function automatic logic [15:0] stamp_gap(logic [SlotW-1:0] a, logic [SlotW-1:0] b);
    return stamps[a] - stamps[b];
  endfunction

  function automatic logic [15:0] duty_ratio(logic [15:0] hi, logic [15:0] per);
    logic [31:0] q;
    q = ({16'd0, hi} << 12) / {16'd0, per};
    return (q > 32'd4095) ? 16'd4095 : q[15:0];
  endfunction

  function automatic logic [15:0] abs_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Apply one accepted transaction; return 1 and the result when it yields one
  function automatic bit predict_meter(in_item_t it, output out_item_t res);
    int               total;
    logic [SlotW-1:0] i;
    logic [15:0]      p1, p2, h1, h2, r1, r2;
    bit               ow;
    total = int'(edges_now) + int'(edges_prev);
    res = '0;
    case (it.op)
      OP_CAPTURE: begin
        wr_slot = wr_slot + 1'b1;
        stamps[wr_slot] = it.capture_time;
        if (guard_on && guard_slot == wr_slot) overwritten = 1'b1;
        if (wr_slot[0] && pulses != 16'hFFFF) pulses++;
        if (edges_now != 8'hFF) edges_now++;
        return 0;
      end
      OP_TICK: begin
        edges_prev = edges_now;
        edges_now = '0;
        return 0;
      end
      OP_PERIOD, OP_DUTY: begin
        if (total > 4) begin
          i = wr_slot;
          ow = overwritten;
          guard_slot = slot_back(i, 5);
          guard_on = 1'b1;
          overwritten = 1'b0;
          if (it.op == OP_PERIOD) begin
            if (it.query_edge ^ i[0]) i = slot_back(i, 1);
            p1 = stamp_gap(i, slot_back(i, 2));
            i = slot_back(i, 2);
            p2 = stamp_gap(i, slot_back(i, 2));
            if (ow) res.status = ST_OVERWR;
            else if (abs_gap(p1, p2) < tol) res.value = 16'((17'(p1) + 17'(p2)) >> 1);
            else res.status = ST_MISMATCH;
          end else begin
            if (!it.query_edge ^ i[0]) i = slot_back(i, 1);
            h1 = stamp_gap(i, slot_back(i, 1));
            p1 = stamp_gap(i, slot_back(i, 2));
            i = slot_back(i, 2);
            h2 = stamp_gap(i, slot_back(i, 1));
            p2 = stamp_gap(i, slot_back(i, 2));
            if (ow) res.status = ST_OVERWR;
            else if (p1 == 0 || p2 == 0) res.status = ST_ZERO;
            else begin
              r1 = duty_ratio(h1, p1);
              r2 = duty_ratio(h2, p2);
              if (abs_gap(r1, r2) < tol) res.value = 16'((17'(r1) + 17'(r2)) >> 1);
              else res.status = ST_MISMATCH;
            end
          end
        end else if (it.op == OP_DUTY && total == 0) begin
          res.value = (!it.query_edge ^ it.pin_level) ? 16'd4095 : 16'd0;
        end else begin
          res.status = ST_FEW;
        end
        return 1;
      end
      OP_COUNT: begin
        res.value = pulses;
        pulses = '0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t res;
    out_item_t exp_item;
    if (!rst_n) begin
      tol <= TolReset;
      wr_slot = '1;
      foreach (stamps[k]) stamps[k] = '0;
      guard_slot = '0;
      guard_on = 1'b0;
      overwritten = 1'b0;
      edges_now = '0;
      edges_prev = '0;
      pulses = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) tol <= cfg_tol;
      // Predict on each accepted input transaction
      if (in_valid && !in_stall && predict_meter(in_data, res))
        expected_results.push_back(res);
      // Compare each accepted output transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result value=%0d status=%0d",
                                        out_data.value, out_data.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = expected_results.pop_front();
          if (exp_item.value !== out_data.value || exp_item.status !== out_data.status) begin
            if (fail_count < 10)
              $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       exp_item.value, exp_item.status, out_data.value, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/tb_capture_period_duty_meter_core.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the meter core, with the checker alongside
module tb_capture_period_duty_meter_core;
  import cpdm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 29;
  int          recv_idle_pct = 52;
  int          hold_len = 0;
  int          hold_cnt = 0;
  logic [15:0] timer_now = '0;

  always #6 clk = ~clk;

  capture_period_duty_meter_core u_dut (.*);

  cpdm_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_write(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_tol(cfg_pwdata[15:0]), .fail_count, .pending
  );

  // Receiver: random stall, or a long hold-off counted here once requested
  always @(posedge clk) begin
    if (hold_cnt < hold_len) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_tolerance(logic [15:0] tol);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= {16'd0, tol};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic [2:0] op, logic [15:0] t, logic qe, logic pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, capture_time: t, query_edge: qe, pin_level: pin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Capture an edge a random gap after the previous one
  task automatic send_edge(int lo, int hi);
    timer_now = timer_now + 16'($urandom_range(hi, lo));
    send_item(OP_CAPTURE, timer_now, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_items(int n);
    int k;
    int e;
    int per;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // Regular waveform burst followed by a query
          per = $urandom_range(400, 2);
          for (e = 0; e < $urandom_range(8, 1); e++) begin
            send_edge(per, per + $urandom_range(3));
            k++;
          end
          send_item($urandom_range(1) ? OP_PERIOD : OP_DUTY, 16'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        4: send_item(OP_TICK, 16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        5: send_item(OP_COUNT, 16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        6: send_item(3'($urandom_range(7)), 16'($urandom), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        7: send_item(OP_CAPTURE, 16'($urandom), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        default: send_edge(0, 65535);
      endcase
    end
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: duty with no edges, too few edges, zero periods, unused ops
    send_item(OP_DUTY, 16'h0000, 1'b0, 1'b0);
    send_item(OP_DUTY, 16'hFFFF, 1'b1, 1'b0);
    send_item(OP_DUTY, 16'h0000, 1'b0, 1'b1);
    send_item(OP_DUTY, 16'hFFFF, 1'b1, 1'b1);
    send_item(OP_PERIOD, 16'h0000, 1'b0, 1'b0);
    send_item(OP_COUNT, 16'h0000, 1'b0, 1'b0);
    send_item(3'd5, 16'hFFFF, 1'b1, 1'b1);
    send_item(3'd6, 16'h0000, 1'b0, 1'b0);
    send_item(3'd7, 16'hFFFF, 1'b1, 1'b1);
    for (k = 0; k < 6; k++) send_item(OP_CAPTURE, 16'h0000, 1'b0, 1'b0);
    send_item(OP_DUTY, 16'h0000, 1'b0, 1'b0);
    send_item(OP_PERIOD, 16'h0000, 1'b1, 1'b0);
    send_item(OP_TICK, 16'h0000, 1'b0, 1'b0);
    for (k = 0; k < 6; k++) send_item(OP_CAPTURE, 16'(k * 16'h3000), 1'b0, 1'b0);
    send_item(OP_PERIOD, 16'h0000, 1'b0, 1'b0);
    send_item(OP_DUTY, 16'h0000, 1'b1, 1'b0);
    send_item(OP_COUNT, 16'h0000, 1'b0, 1'b0);
    drain();
    // Random with several tolerances, extremes included
    write_tolerance(16'd0);
    random_items(150);
    drain();
    write_tolerance(16'hFFFF);
    random_items(150);
    // Long receiver hold-off while the sender keeps going
    hold_len <= 300;
    random_items(30);
    drain();
    send_idle_pct = 52;
    recv_idle_pct = 29;
    write_tolerance(16'd40);
    random_items(250);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(TolReset);
    random_items(220);
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
